// ----- rtl/core/tat_pkg.sv -----
// Shared types and constants of the template alternative tokenizer.
// Holds the result beat layout, the result kind and error codes and the register map.
// Depends on nothing.
`default_nettype none

package tat_pkg;

	// Kind of a result beat.
	typedef enum logic [2:0] {
		K_STATIC = 3'd0,
		K_DYN    = 3'd1,
		K_TAG    = 3'd2,
		K_OPEN   = 3'd3,
		K_ALT    = 3'd4,
		K_CLOSE  = 3'd5,
		K_END    = 3'd6
	} kind_t;

	// Error code carried by the end beat.
	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_SECTION = 2'd1,
		ERR_TAG     = 2'd2,
		ERR_CLOSE   = 2'd3
	} err_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_OPEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_CLOSE = 3'd4;

	// Register reset values.
	localparam logic [7:0] OPEN_RST      = 8'h5B;
	localparam logic [7:0] CLOSE_RST     = 8'h5D;
	localparam logic [7:0] ALT_RST       = 8'h7C;
	localparam logic [7:0] TAG_OPEN_RST  = 8'h28;
	localparam logic [7:0] TAG_CLOSE_RST = 8'h29;

	// Result queue: four entries, room for two results of one item.
	localparam int unsigned QD   = 4;
	localparam int unsigned QA_W = 2;
	localparam int unsigned QC_W = 3;

	// One result beat.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		err_t        err;
		logic [15:0] sec;
		logic [7:0]  alt;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/template_alternative_tokenizer.sv -----
// Top level of the template alternative tokenizer: input stage, parser and result queue.
// Uses tat_pkg for the result beat layout, the codes and the register map.
// Single module; no submodules.
//
// Usage
// The input channel (in_valid, in_ready, mode, data_byte) carries one byte or an end-of-input
// mark per beat. The output channel (out_valid, out_ready and the result fields) carries zero,
// one or two result beats per input beat, the last of them flagged by last. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the five delimiter registers; it
// is always ready and should only be used while the block is idle.
// An accepted beat is held in an input register, classified against the parser state while
// it is held there, and its results are written into a four-entry result queue. The first
// result is offered from the queue after that write; while the queue lacks room for two
// results, the beat waits in the input register.
// One input beat is taken per cycle as long as the queue has room for two results; the
// sustained rate is set by the output port, which delivers one result per cycle while
// out_ready is high, so items giving two results are taken at a lower rate.
// When the receiver stalls, results collect in the queue and the input stage stops taking
// beats once fewer than two entries are free; nothing is dropped.
// Reset empties the queue and the input stage, returns the parser to static text with both
// counters cleared and loads the default delimiters. An end-of-input beat also returns the
// parser state to its reset values, so a new stream may follow directly.
`default_nettype none

module template_alternative_tokenizer
	import tat_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	// Input channel
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  mode,
	input  wire  [7:0]           data_byte,
	// Output channel
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [2:0]           kind,
	output logic [7:0]           char_out,
	output logic [1:0]           error_code,
	output logic [15:0]          section_index,
	output logic [7:0]           alternative_index,
	output logic                 last,
	// Configuration channel
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [7:0]           cfg_data
);

	// Parser states. A "have" state means one delimiter byte has been seen and its twin is
	// awaited.
	typedef enum logic [3:0] {
		ST_TEXT      = 4'd0,
		ST_HAVE_OPEN = 4'd1,
		ST_SEC_START = 4'd2,
		ST_TAG_OPEN1 = 4'd3,
		ST_TAG       = 4'd4,
		ST_TAG_CLOSE = 4'd5,
		ST_BODY      = 4'd6,
		ST_HAVE_ALT  = 4'd7,
		ST_HAVE_CLS  = 4'd8
	} state_t;

	// Delimiter registers.
	logic [7:0] open_q, close_q, alt_q, tag_open_q, tag_close_q;

	// Parser state.
	state_t      state_q, state_d;
	logic [15:0] sec_q, sec_upd;
	logic [7:0]  altc_q, altc_upd;
	logic        seen_q, seen_upd;

	// Input stage.
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// Result queue.
	result_t         queue_q [QD];
	logic [QA_W-1:0] head_q, tail_q;
	logic [QC_W-1:0] cnt_q;
	logic            pop;

	// Results of the item in the input stage.
	logic [1:0] n_res;
	kind_t      k0, k1;
	logic [7:0] c0, c1;
	err_t       err;
	result_t    r0, r1;

	// Configuration writes are always taken; indexes beyond the map are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= OPEN_RST;
			close_q     <= CLOSE_RST;
			alt_q       <= ALT_RST;
			tag_open_q  <= TAG_OPEN_RST;
			tag_close_q <= TAG_CLOSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OPEN:      open_q      <= cfg_data;
				REG_CLOSE:     close_q     <= cfg_data;
				REG_ALT:       alt_q       <= cfg_data;
				REG_TAG_OPEN:  tag_open_q  <= cfg_data;
				REG_TAG_CLOSE: tag_close_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held beat is processed when the queue can take two results, whatever the output does.
	assign advance  = valid_s1 && (cnt_q <= QC_W'(QD - 2));
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
		end
	end

	// Classification of the held beat. Counters are updated first; every result of a data
	// beat carries the updated counters, and the end beat carries them unchanged because an
	// end mark never touches them before the clear.
	always_comb begin
		state_d  = state_q;
		sec_upd  = sec_q;
		altc_upd = altc_q;
		seen_upd = seen_q;
		n_res    = 2'd0;
		k0       = K_STATIC;
		c0       = 8'd0;
		k1       = K_STATIC;
		c1       = 8'd0;
		err      = ERR_OK;
		if (mode_s1) begin
			case (state_q)
				ST_SEC_START, ST_TAG_OPEN1, ST_BODY, ST_HAVE_ALT: err = ERR_SECTION;
				ST_TAG, ST_TAG_CLOSE:                             err = ERR_TAG;
				ST_HAVE_CLS:                                      err = ERR_CLOSE;
				default:                                          err = ERR_OK;
			endcase
			if (state_q == ST_HAVE_OPEN) begin
				// A pending open byte is flushed as static text before the end beat.
				n_res = 2'd2;
				k0    = K_STATIC;
				c0    = open_q;
				k1    = K_END;
			end else begin
				n_res = 2'd1;
				k0    = K_END;
			end
			state_d = ST_TEXT;
		end else begin
			case (state_q)
				ST_HAVE_OPEN: begin
					if (byte_s1 == open_q) begin
						if (seen_q) begin
							if (sec_q != 16'hFFFF) sec_upd = sec_q + 16'd1;
						end else begin
							seen_upd = 1'b1;
						end
						altc_upd = 8'd0;
						n_res    = 2'd1;
						k0       = K_OPEN;
						state_d  = ST_SEC_START;
					end else begin
						n_res   = 2'd2;
						c0      = open_q;
						c1      = byte_s1;
						state_d = ST_TEXT;
					end
				end
				ST_SEC_START: begin
					// The first byte of a section is literal unless it starts a tag.
					if (byte_s1 == tag_open_q) begin
						state_d = ST_TAG_OPEN1;
					end else begin
						n_res   = 2'd1;
						k0      = K_DYN;
						c0      = byte_s1;
						state_d = ST_BODY;
					end
				end
				ST_TAG_OPEN1: begin
					if (byte_s1 == tag_open_q) begin
						state_d = ST_TAG;
					end else begin
						n_res   = 2'd2;
						k0      = K_DYN;
						c0      = tag_open_q;
						k1      = K_DYN;
						c1      = byte_s1;
						state_d = ST_BODY;
					end
				end
				ST_TAG: begin
					if (byte_s1 == tag_close_q) begin
						state_d = ST_TAG_CLOSE;
					end else begin
						n_res = 2'd1;
						k0    = K_TAG;
						c0    = byte_s1;
					end
				end
				ST_TAG_CLOSE: begin
					if (byte_s1 == tag_close_q) begin
						state_d = ST_BODY;
					end else begin
						n_res   = 2'd2;
						k0      = K_TAG;
						c0      = tag_close_q;
						k1      = K_TAG;
						c1      = byte_s1;
						state_d = ST_TAG;
					end
				end
				ST_BODY: begin
					// The alternative separator wins where it equals the close byte.
					if (byte_s1 == alt_q) begin
						state_d = ST_HAVE_ALT;
					end else if (byte_s1 == close_q) begin
						state_d = ST_HAVE_CLS;
					end else begin
						n_res = 2'd1;
						k0    = K_DYN;
						c0    = byte_s1;
					end
				end
				ST_HAVE_ALT: begin
					if (byte_s1 == alt_q) begin
						if (altc_q != 8'hFF) altc_upd = altc_q + 8'd1;
						n_res = 2'd1;
						k0    = K_ALT;
					end else begin
						n_res = 2'd2;
						k0    = K_DYN;
						c0    = alt_q;
						k1    = K_DYN;
						c1    = byte_s1;
					end
					state_d = ST_BODY;
				end
				ST_HAVE_CLS: begin
					if (byte_s1 == close_q) begin
						n_res   = 2'd1;
						k0      = K_CLOSE;
						state_d = ST_TEXT;
					end else begin
						n_res   = 2'd2;
						k0      = K_DYN;
						c0      = close_q;
						k1      = K_DYN;
						c1      = byte_s1;
						state_d = ST_BODY;
					end
				end
				default: begin
					if (byte_s1 == open_q) begin
						state_d = ST_HAVE_OPEN;
					end else begin
						n_res   = 2'd1;
						c0      = byte_s1;
						state_d = ST_TEXT;
					end
				end
			endcase
		end
	end

	// Only the end beat carries an error code, and it is always the final result.
	always_comb begin
		r0.kind = k0;
		r0.ch   = c0;
		r0.err  = (k0 == K_END) ? err : ERR_OK;
		r0.sec  = sec_upd;
		r0.alt  = altc_upd;
		r0.last = (n_res == 2'd1);
		r1.kind = k1;
		r1.ch   = c1;
		r1.err  = (k1 == K_END) ? err : ERR_OK;
		r1.sec  = sec_upd;
		r1.alt  = altc_upd;
		r1.last = 1'b1;
	end

	// Parser state register; an end beat returns everything to the reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TEXT;
			sec_q   <= 16'd0;
			altc_q  <= 8'd0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			state_q <= state_d;
			if (mode_s1) begin
				sec_q  <= 16'd0;
				altc_q <= 8'd0;
				seen_q <= 1'b0;
			end else begin
				sec_q  <= sec_upd;
				altc_q <= altc_upd;
				seen_q <= seen_upd;
			end
		end
	end

	// Result queue: up to two entries written per cycle, one read at the head.
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) head_q <= head_q + QA_W'(1);
			if (advance) tail_q <= tail_q + QA_W'(n_res);
			cnt_q <= cnt_q + (advance ? QC_W'(n_res) : QC_W'(0)) - (pop ? QC_W'(1) : QC_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) queue_q[tail_q] <= r0;
		if (advance && n_res == 2'd2) queue_q[tail_q + QA_W'(1)] <= r1;
	end

	assign out_valid         = (cnt_q != '0);
	assign kind              = queue_q[head_q].kind;
	assign char_out          = queue_q[head_q].ch;
	assign error_code        = queue_q[head_q].err;
	assign section_index     = queue_q[head_q].sec;
	assign alternative_index = queue_q[head_q].alt;
	assign last              = queue_q[head_q].last;

`ifndef SYNTHESIS
	// The queue never holds more results than it has entries.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC_W'(QD))
		else $error("result queue overfilled");

	// An end beat leaves the parser in its reset state.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 |=> state_q == ST_TEXT && sec_q == 16'd0 && altc_q == 8'd0 && !seen_q)
		else $error("parser state not cleared after end of input");

	// Every processed end beat yields an end result flagged as last.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 |-> n_res != 2'd0 && (n_res == 2'd1 ? r0.kind == K_END : r1.kind == K_END))
		else $error("end of input produced no end result");

	// A section counter other than zero only exists once a section has been opened.
	a_seen: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q != 16'd0 |-> seen_q)
		else $error("section counter advanced before any section opened");
`endif

endmodule

`default_nettype wire

// ----- test/tat_checker.sv -----
// Checker for the template alternative tokenizer: watches the input, result and register
// channels, works out the tokens each input beat should give and compares them in order.
// Depends on tat_pkg for the result layout, the kind and error codes and the register map.
`timescale 1ns / 1ps

module tat_checker
	import tat_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_ready,
	input  wire                 mode,
	input  wire [7:0]           data_byte,
	input  wire                 out_valid,
	input  wire                 out_ready,
	input  wire [2:0]           kind,
	input  wire [7:0]           char_out,
	input  wire [1:0]           error_code,
	input  wire [15:0]          section_index,
	input  wire [7:0]           alternative_index,
	input  wire                 last,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [7:0]           cfg_data,
	output int unsigned         fail_count,
	output int unsigned         tokens_owed
);

	// Where the parser stands between two bytes.
	typedef enum logic [3:0] {
		PS_TEXT,
		PS_HAVE_OPEN,
		PS_SEC_START,
		PS_TAG_OPEN1,
		PS_TAG,
		PS_TAG_CLOSE,
		PS_BODY,
		PS_HAVE_ALT,
		PS_HAVE_CLS
	} parse_state_t;

	logic [7:0]   open_ch, close_ch, alt_ch, tag_open_ch, tag_close_ch;
	parse_state_t parse_q;
	logic [15:0]  sec_cnt;
	logic [7:0]   alt_cnt;
	logic         sec_seen;

	result_t      owed_tokens [$];
	result_t      want;

	// Queues one token stamped with the counters as they stand now.
	task automatic owe(input kind_t k, input logic [7:0] ch, input err_t e);
		result_t t;
		t.kind = k;
		t.ch   = ch;
		t.err  = e;
		t.sec  = sec_cnt;
		t.alt  = alt_cnt;
		t.last = 1'b0;
		owed_tokens.push_back(t);
	endtask

	// Advances the parser by one input beat and queues the tokens it gives.
	task automatic tokenize(input logic eoi, input logic [7:0] c);
		int      base;
		err_t    err;
		result_t tail;
		base = owed_tokens.size();
		err  = ERR_OK;
		if (eoi) begin
			case (parse_q)
				PS_HAVE_OPEN: owe(K_STATIC, open_ch, ERR_OK);
				PS_SEC_START, PS_TAG_OPEN1, PS_BODY, PS_HAVE_ALT: err = ERR_SECTION;
				PS_TAG, PS_TAG_CLOSE: err = ERR_TAG;
				PS_HAVE_CLS: err = ERR_CLOSE;
				default: ;
			endcase
			owe(K_END, 8'h00, err);
			parse_q  = PS_TEXT;
			sec_cnt  = '0;
			alt_cnt  = '0;
			sec_seen = 1'b0;
		end else begin
			case (parse_q)
				PS_HAVE_OPEN: begin
					if (c == open_ch) begin
						if (sec_seen) begin
							if (sec_cnt != 16'hFFFF) sec_cnt++;
						end else begin
							sec_seen = 1'b1;
						end
						alt_cnt = '0;
						owe(K_OPEN, 8'h00, ERR_OK);
						parse_q = PS_SEC_START;
					end else begin
						owe(K_STATIC, open_ch, ERR_OK);
						owe(K_STATIC, c, ERR_OK);
						parse_q = PS_TEXT;
					end
				end
				PS_SEC_START: begin
					if (c == tag_open_ch) begin
						parse_q = PS_TAG_OPEN1;
					end else begin
						owe(K_DYN, c, ERR_OK);
						parse_q = PS_BODY;
					end
				end
				PS_TAG_OPEN1: begin
					if (c == tag_open_ch) begin
						parse_q = PS_TAG;
					end else begin
						owe(K_DYN, tag_open_ch, ERR_OK);
						owe(K_DYN, c, ERR_OK);
						parse_q = PS_BODY;
					end
				end
				PS_TAG: begin
					if (c == tag_close_ch) parse_q = PS_TAG_CLOSE;
					else owe(K_TAG, c, ERR_OK);
				end
				PS_TAG_CLOSE: begin
					if (c == tag_close_ch) begin
						parse_q = PS_BODY;
					end else begin
						owe(K_TAG, tag_close_ch, ERR_OK);
						owe(K_TAG, c, ERR_OK);
						parse_q = PS_TAG;
					end
				end
				PS_BODY: begin
					// The alternative separator wins where it equals the closer.
					if (c == alt_ch) parse_q = PS_HAVE_ALT;
					else if (c == close_ch) parse_q = PS_HAVE_CLS;
					else owe(K_DYN, c, ERR_OK);
				end
				PS_HAVE_ALT: begin
					if (c == alt_ch) begin
						if (alt_cnt != 8'hFF) alt_cnt++;
						owe(K_ALT, 8'h00, ERR_OK);
					end else begin
						owe(K_DYN, alt_ch, ERR_OK);
						owe(K_DYN, c, ERR_OK);
					end
					parse_q = PS_BODY;
				end
				PS_HAVE_CLS: begin
					if (c == close_ch) begin
						owe(K_CLOSE, 8'h00, ERR_OK);
						parse_q = PS_TEXT;
					end else begin
						owe(K_DYN, close_ch, ERR_OK);
						owe(K_DYN, c, ERR_OK);
						parse_q = PS_BODY;
					end
				end
				default: begin
					if (c == open_ch) begin
						parse_q = PS_HAVE_OPEN;
					end else begin
						owe(K_STATIC, c, ERR_OK);
						parse_q = PS_TEXT;
					end
				end
			endcase
		end
		if (owed_tokens.size() > base) begin
			tail = owed_tokens.pop_back();
			tail.last = 1'b1;
			owed_tokens.push_back(tail);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_ch      = OPEN_RST;
			close_ch     = CLOSE_RST;
			alt_ch       = ALT_RST;
			tag_open_ch  = TAG_OPEN_RST;
			tag_close_ch = TAG_CLOSE_RST;
			parse_q      = PS_TEXT;
			sec_cnt      = '0;
			alt_cnt      = '0;
			sec_seen     = 1'b0;
			owed_tokens.delete();
			fail_count   = 0;
		end else begin
			// Results are compared before the new input is predicted; its tokens
			// cannot leave the block in the same cycle.
			if (out_valid && out_ready) begin
				if (owed_tokens.size() == 0) begin
					$display("%0t: result beat expected none, got kind %0h char %0h",
						$time, kind, char_out);
					fail_count++;
				end else begin
					want = owed_tokens.pop_front();
					check_field("kind", 16'(want.kind), 16'(kind));
					check_field("char_out", 16'(want.ch), 16'(char_out));
					check_field("error_code", 16'(want.err), 16'(error_code));
					check_field("section_index", want.sec, section_index);
					check_field("alternative_index", 16'(want.alt), 16'(alternative_index));
					check_field("last", 16'(want.last), 16'(last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OPEN:      open_ch      = cfg_data;
					REG_CLOSE:     close_ch     = cfg_data;
					REG_ALT:       alt_ch       = cfg_data;
					REG_TAG_OPEN:  tag_open_ch  = cfg_data;
					REG_TAG_CLOSE: tag_close_ch = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) tokenize(mode, data_byte);
		end
		tokens_owed = owed_tokens.size();
	end

endmodule

// ----- test/template_alternative_tokenizer_tb.sv -----
// Testbench top for the template alternative tokenizer: clock, reset, byte stream stimulus,
// register writes and the verdict. Prediction and comparison live in tat_checker.
// Depends on tat_pkg, tat_checker and the tokenizer RTL.
`timescale 1ns / 1ps

module template_alternative_tokenizer_tb;
	import tat_pkg::*;

	// A correct run stays far below this limit.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// A beat that gives no token may still be inside the block
	// when the last owed token has arrived.
	localparam int unsigned DRAIN_SLACK = 4;
	// Enough alternatives to push their counter into saturation, then a few short
	// sections after it.
	localparam int unsigned SAT_ALTS      = 260;
	localparam int unsigned TAIL_SECTIONS = 3;
	localparam logic [7:0]  FILL_CH       = 8'h61;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [7:0]           data_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           kind;
	logic [7:0]           char_out;
	logic [1:0]           error_code;
	logic [15:0]          section_index;
	logic [7:0]           alternative_index;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	int unsigned fail_count;
	int unsigned tokens_owed;
	int unsigned cycle_count;
	int unsigned beats_sent;
	int unsigned gap_pct;
	int unsigned stall_pct;

	// The stimulus keeps its own view of the delimiters so that it can build
	// templates that the block will actually recognise.
	logic [7:0] delims [5];

	template_alternative_tokenizer i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.data_byte         (data_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.kind              (kind),
		.char_out          (char_out),
		.error_code        (error_code),
		.section_index     (section_index),
		.alternative_index (alternative_index),
		.last              (last),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	tat_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.data_byte         (data_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.kind              (kind),
		.char_out          (char_out),
		.error_code        (error_code),
		.section_index     (section_index),
		.alternative_index (alternative_index),
		.last              (last),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.fail_count        (fail_count),
		.tokens_owed       (tokens_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a correct run never gets near the limit, so reaching it is a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: drops ready for bursts of random length, as often as stall_pct says.
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				out_ready = 1'b0;
				repeat ($urandom_range(6)) @(negedge clk);
				@(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	function automatic logic [7:0] rnd_byte();
		logic [31:0] r;
		r = $urandom();
		return r[7:0];
	endfunction

	// A content byte: mostly anything, now and then one of the delimiters so that
	// lone delimiters and accidental doubles turn up inside otherwise tidy text.
	function automatic logic [7:0] pick_byte(input int unsigned delim_pct);
		if ($urandom_range(99) < delim_pct) return delims[$urandom_range(4)];
		return rnd_byte();
	endfunction

	// Offers one beat on the input channel. Valid stays high after acceptance and is
	// only lowered when a gap follows, so it is never dropped and raised in one step.
	task automatic send_beat(input logic eoi, input logic [7:0] c);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(6)) @(negedge clk);
		end
		@(negedge clk);
		in_valid  = 1'b1;
		mode      = eoi;
		data_byte = c;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_beat(1'b0, c);
	endtask

	task automatic send_pair(input logic [7:0] c);
		send_byte(c);
		send_byte(c);
	endtask

	task automatic send_end();
		// The data byte of an end-of-input beat is ignored, so it is left random.
		send_beat(1'b1, rnd_byte());
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_run(input int unsigned len, input int unsigned delim_pct);
		repeat (len) send_byte(pick_byte(delim_pct));
	endtask

	// A well-formed stream: static text and sections, some with a tag, with a few
	// alternatives each, closed by an end-of-input beat most of the time.
	task automatic send_template();
		int unsigned parts;
		parts = $urandom_range(1, 3);
		repeat (parts) begin
			send_run($urandom_range(0, 4), 5);
			send_pair(delims[REG_OPEN]);
			if ($urandom_range(2) == 0) begin
				send_pair(delims[REG_TAG_OPEN]);
				send_run($urandom_range(0, 3), 10);
				send_pair(delims[REG_TAG_CLOSE]);
			end
			repeat ($urandom_range(3)) begin
				send_run($urandom_range(1, 3), 10);
				send_pair(delims[REG_ALT]);
			end
			send_run($urandom_range(1, 3), 10);
			send_pair(delims[REG_CLOSE]);
		end
		send_run($urandom_range(0, 3), 5);
		if ($urandom_range(9) != 0) send_end();
	endtask

	// A stream cut short at some point of a section, so that every error code of the
	// end beat comes up, plus a lone opener left pending at the end.
	task automatic send_broken();
		int unsigned cut;
		cut = $urandom_range(7);
		send_run($urandom_range(0, 2), 5);
		if (cut == 7) send_byte(delims[REG_OPEN]);
		else send_pair(delims[REG_OPEN]);
		case (cut)
			1: send_byte(delims[REG_TAG_OPEN]);
			2: begin
				send_pair(delims[REG_TAG_OPEN]);
				send_run($urandom_range(0, 2), 0);
			end
			3: begin
				send_pair(delims[REG_TAG_OPEN]);
				send_run($urandom_range(0, 2), 0);
				send_byte(delims[REG_TAG_CLOSE]);
			end
			4: send_run($urandom_range(1, 3), 0);
			5: begin
				send_run($urandom_range(1, 2), 0);
				send_byte(delims[REG_ALT]);
			end
			6: begin
				send_run($urandom_range(1, 2), 0);
				send_byte(delims[REG_CLOSE]);
			end
			default: ;
		endcase
		send_end();
	endtask

	// Noise: delimiter-heavy bytes with the odd end-of-input beat among them.
	task automatic send_noise();
		repeat ($urandom_range(1, 12)) send_beat($urandom_range(9) == 0, pick_byte(40));
	endtask

	// Stops the sender and waits until every owed token has come out, then a little
	// longer for a beat that gives no token at all.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (tokens_owed != 0) @(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx <= REG_TAG_CLOSE) delims[idx] = v;
	endtask

	task automatic load_delims(input logic [7:0] o, input logic [7:0] c, input logic [7:0] a,
			input logic [7:0] to, input logic [7:0] tc);
		write_reg(REG_OPEN, o);
		write_reg(REG_CLOSE, c);
		write_reg(REG_ALT, a);
		write_reg(REG_TAG_OPEN, to);
		write_reg(REG_TAG_CLOSE, tc);
	endtask

	// One random phase under the current delimiters; it ends with the block idle.
	task automatic run_phase(input int unsigned beats, input int unsigned idle_pct);
		int unsigned stop_at;
		int unsigned pick;
		stop_at   = beats_sent + beats;
		gap_pct   = idle_pct;
		stall_pct = idle_pct;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(9);
			if (pick < 6) send_template();
			else if (pick < 8) send_broken();
			else send_noise();
		end
		drain();
	endtask

	initial begin
		logic [7:0] v [5];

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = 1'b0;
		data_byte  = 8'h00;
		cfg_valid  = 1'b0;
		cfg_index  = REG_OPEN;
		cfg_data   = 8'h00;
		beats_sent = 0;
		gap_pct    = 0;
		stall_pct  = 0;
		delims[REG_OPEN]      = OPEN_RST;
		delims[REG_CLOSE]     = CLOSE_RST;
		delims[REG_ALT]       = ALT_RST;
		delims[REG_TAG_OPEN]  = TAG_OPEN_RST;
		delims[REG_TAG_CLOSE] = TAG_CLOSE_RST;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset delimiters. A lone opener is followed by a byte
		// with every bit set; the first section opens straight into a tag holding a zero
		// byte and a lone tag closer, then a real alternative, a lone separator whose
		// partner is a closer, and a proper close.
		gap_pct   = 20;
		stall_pct = 20;
		send_text("[");
		send_byte(8'hFF);
		send_text("[[((");
		send_byte(8'h00);
		send_text(")|))|||]]]");
		// Second section: a closer as its first byte is plain dynamic text, and a
		// single closer left hanging gives the pending-close error at the end.
		send_text("[[]]");
		send_end();
		// A lone opener at the end comes out as static text.
		send_text("[");
		send_end();
		drain();

		run_phase(200, 10);

		// All delimiters equal, at both extremes of the byte.
		load_delims(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		run_phase(80, 30);
		load_delims(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_phase(80, 0);

		// Arbitrary delimiters; the unused register indexes take writes that must
		// change nothing. The sender also pauses half way until all tokens are out.
		load_delims(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
		for (int idx = REG_TAG_CLOSE + 1; idx < 2 ** CFG_IDX_W; idx++)
			write_reg(idx[CFG_IDX_W-1:0], rnd_byte());
		run_phase(80, 60);
		run_phase(80, 60);

		// Pairs that coincide: the separator equals the closer, the tag opener equals
		// the section opener and the tag closer equals the closer too.
		load_delims(8'h3C, 8'h3E, 8'h3E, 8'h3C, 8'h3E);
		run_phase(120, 20);

		// Delimiters drawn from a handful of values, so coincidences come and go.
		repeat (2) begin
			foreach (v[k]) v[k] = rnd_byte() & 8'h43;
			load_delims(v[0], v[1], v[2], v[3], v[4]);
			run_phase(80, 40);
		end

		// Last part, with no idling: one section with enough alternatives to saturate
		// its counter, then a few short sections that count on from it.
		load_delims(OPEN_RST, CLOSE_RST, ALT_RST, TAG_OPEN_RST, TAG_CLOSE_RST);
		gap_pct   = 0;
		stall_pct = 0;
		send_pair(delims[REG_OPEN]);
		send_byte(FILL_CH);
		repeat (SAT_ALTS) send_pair(delims[REG_ALT]);
		send_pair(delims[REG_CLOSE]);
		repeat (TAIL_SECTIONS) begin
			send_pair(delims[REG_OPEN]);
			send_byte(FILL_CH);
			send_pair(delims[REG_CLOSE]);
		end
		send_end();
		drain();

		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
